// ===== hw/rtl/kst_pkg.sv =====
`timescale 1ns / 1ps

package kst_pkg;

  localparam int KEY_COUNT = 128;
  localparam int KEY_W     = 7;
  localparam int SCAN_W    = 8;
  localparam int CODE_W    = 16;
  localparam int QCOUNT_W  = 6;

  // modifier key numbers
  localparam logic [KEY_W-1:0] KEY_LSHIFT = 7'h60;
  localparam logic [KEY_W-1:0] KEY_RSHIFT = 7'h61;
  localparam logic [KEY_W-1:0] KEY_CAPS   = 7'h62;
  localparam logic [KEY_W-1:0] KEY_CTRL   = 7'h63;
  localparam logic [KEY_W-1:0] KEY_ALT    = 7'h64;

  // scan code layout: release flag on top, key number below
  localparam int RELEASE_BIT = SCAN_W - 1;

  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_POP   = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  typedef struct packed {
    logic shift;
    logic caps;
    logic ctrl;
    logic alt;
  } mods_t;

  // beat handed from the key stage to the ring stage
  typedef struct packed {
    logic              is_press;
    logic              is_pop;
    logic [CODE_W-1:0] code;
    mods_t             mods;
  } kst_beat_t;

endpackage

// ===== hw/rtl/kst_key_stage.sv =====
`timescale 1ns / 1ps

module kst_key_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_command,
  input  logic [kst_pkg::SCAN_W-1:0] in_scan_code,
  input  logic [kst_pkg::KEY_W-1:0]  in_table_index,
  input  logic                       in_table_shifted,
  input  logic [kst_pkg::CODE_W-1:0] in_table_value,
  output logic                       s1_valid,
  input  logic                       s1_ready,
  output kst_pkg::kst_beat_t         s1_beat
);

  import kst_pkg::*;

  logic [CODE_W-1:0] plain_mem   [KEY_COUNT];
  logic [CODE_W-1:0] shifted_mem [KEY_COUNT];

  logic [KEY_COUNT-1:0] held_r;
  logic [KEY_COUNT-1:0] held_nxt;
  logic                 s1_valid_r;
  logic                 s1_press_r;
  logic                 s1_pop_r;
  logic                 shift_sel_r;
  mods_t                mods_r;
  logic [CODE_W-1:0]    plain_rd_r;
  logic [CODE_W-1:0]    shifted_rd_r;

  logic             in_fire;
  logic             is_key;
  logic             is_release;
  logic [KEY_W-1:0] key;
  mods_t            mods_nxt;
  logic             plain_we;
  logic             shifted_we;

  assign in_ready   = !s1_valid_r || s1_ready;
  assign in_fire    = in_valid && in_ready;
  assign is_key     = (in_command == CMD_KEY);
  assign is_release = in_scan_code[RELEASE_BIT];
  assign key        = in_scan_code[KEY_W-1:0];
  assign plain_we   = in_fire && (in_command == CMD_WRITE) && !in_table_shifted;
  assign shifted_we = in_fire && (in_command == CMD_WRITE) && in_table_shifted;

  always_comb begin
    held_nxt = held_r;
    if (is_key) begin
      held_nxt[key] = !is_release;
    end
    mods_nxt.shift = held_nxt[KEY_LSHIFT] || held_nxt[KEY_RSHIFT];
    mods_nxt.caps  = held_nxt[KEY_CAPS];
    mods_nxt.ctrl  = held_nxt[KEY_CTRL];
    mods_nxt.alt   = held_nxt[KEY_ALT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        held_r     <= held_nxt;
        s1_valid_r <= 1'b1;
      end else if (s1_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_press_r  <= is_key && !is_release;
      s1_pop_r    <= (in_command == CMD_POP);
      shift_sel_r <= mods_nxt.shift;
      mods_r      <= mods_nxt;
    end
  end

  // keymaps: one write port, registered read at the key number of every accepted beat
  always_ff @(posedge clk) begin
    if (plain_we) begin
      plain_mem[in_table_index] <= in_table_value;
    end
    if (in_fire) begin
      plain_rd_r <= plain_mem[key];
    end
  end

  always_ff @(posedge clk) begin
    if (shifted_we) begin
      shifted_mem[in_table_index] <= in_table_value;
    end
    if (in_fire) begin
      shifted_rd_r <= shifted_mem[key];
    end
  end

  assign s1_valid         = s1_valid_r;
  assign s1_beat.is_press = s1_press_r;
  assign s1_beat.is_pop   = s1_pop_r;
  assign s1_beat.code     = shift_sel_r ? shifted_rd_r : plain_rd_r;
  assign s1_beat.mods     = mods_r;

`ifndef ASSERT_OFF
  a_press_sets_key: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_key && !is_release |=> held_r[$past(key)])
    else $error("press did not set held key");

  a_release_clears_key: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_key && is_release |=> !held_r[$past(key)])
    else $error("release did not clear held key");

  a_stall_holds_beat: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_ready |=> s1_valid_r && $stable(shift_sel_r) && $stable(mods_r))
    else $error("stage beat changed while stalled");
`endif

endmodule

// ===== hw/rtl/kst_ring_stage.sv =====
`timescale 1ns / 1ps

module kst_ring_stage #(
  parameter int RING_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s1_valid,
  output logic                         s1_ready,
  input  kst_pkg::kst_beat_t           s1_beat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_pop_valid,
  output logic [kst_pkg::CODE_W-1:0]   out_pop_code,
  output logic [kst_pkg::QCOUNT_W-1:0] out_queue_count,
  output logic                         out_dropped,
  output kst_pkg::mods_t               out_mods
);

  import kst_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = (PTR_W > QCOUNT_W) ? PTR_W : QCOUNT_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  logic [CODE_W-1:0] ring_mem [RING_DEPTH];

  logic [PTR_W-1:0]    wr_r;
  logic [PTR_W-1:0]    rd_r;
  logic [CODE_W-1:0]   rd_data_r;
  logic                out_valid_r;
  logic                out_pop_valid_r;
  logic [CODE_W-1:0]   out_pop_code_r;
  logic [QCOUNT_W-1:0] out_count_r;
  logic                out_dropped_r;
  mods_t               out_mods_r;

  logic             fire;
  logic             empty;
  logic             full;
  logic             has_code;
  logic             push;
  logic             drop;
  logic             pop;
  logic [PTR_W-1:0] wr_nxt;
  logic [PTR_W-1:0] rd_nxt;
  logic [CNT_W-1:0] cnt_nxt;

  assign s1_ready = !out_valid_r || out_ready;
  assign fire     = s1_valid && s1_ready;
  assign empty    = (wr_r == rd_r);
  assign full     = (ring_next(wr_r) == rd_r);
  assign has_code = s1_beat.is_press && (s1_beat.code != '0);
  assign push     = fire && has_code && !full;
  assign drop     = fire && has_code && full;
  assign pop      = fire && s1_beat.is_pop && !empty;
  assign wr_nxt   = push ? ring_next(wr_r) : wr_r;
  assign rd_nxt   = pop ? ring_next(rd_r) : rd_r;

  // occupancy after this beat, modulo the ring size
  assign cnt_nxt = CNT_W'(wr_nxt) - CNT_W'(rd_nxt)
                 + ((wr_nxt < rd_nxt) ? CNT_W'(RING_DEPTH) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
    end
  end

  // rd_data_r always mirrors the entry at rd_r (look-ahead read, write bypass)
  always_ff @(posedge clk) begin
    if (push) begin
      ring_mem[wr_r] <= s1_beat.code;
    end
    if (push && (wr_r == rd_nxt)) begin
      rd_data_r <= s1_beat.code;
    end else begin
      rd_data_r <= ring_mem[rd_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_pop_valid_r <= pop;
      out_pop_code_r  <= pop ? rd_data_r : '0;
      out_count_r     <= cnt_nxt[QCOUNT_W-1:0];
      out_dropped_r   <= drop;
      out_mods_r      <= s1_beat.mods;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pop_valid   = out_pop_valid_r;
  assign out_pop_code    = out_pop_code_r;
  assign out_queue_count = out_count_r;
  assign out_dropped     = out_dropped_r;
  assign out_mods        = out_mods_r;

`ifndef ASSERT_OFF
  a_head_coherent: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> rd_data_r == ring_mem[rd_r])
    else $error("head register out of step with ring");

  a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !empty)
    else $error("ring empty right after push");

  a_drop_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dropped_r |-> full)
    else $error("code dropped while ring had room");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("pending result lost");
`endif

endmodule

// ===== hw/rtl/keyboard_scancode_translator_top.sv =====
`timescale 1ns / 1ps

// Keyboard scancode translator. Each input beat is a raw key event (bit 7 =
// release, bits 6:0 = key number), a pop of the oldest queued code, or a
// write of one entry of the plain or shifted keymap. Events keep a 128-bit
// held-key map; a press looks the key up in the shifted keymap when key 0x60
// or 0x61 is held (the press itself counts) and in the plain keymap
// otherwise, and a nonzero code goes into a ring of RING_DEPTH slots that
// holds up to RING_DEPTH-1 codes, or is discarded with out_dropped set when
// the ring is full. Every beat gives exactly one result carrying the pop
// outcome, the ring occupancy (low 6 bits) and the held modifiers. Rate is
// one beat per clock while the output is not stalled. Once its input is
// accepted, the key stage does the registered keymap read; the ring stage,
// once it takes that beat, updates the ring pointers and loads the output
// register. Both channels use valid/ready; with the output stalled the
// block still takes one more beat.
// Keymap entries must be written before any press reads them; there is no
// clearing pass after reset, and only the held-key map, ring pointers and
// valid flags are reset.

module keyboard_scancode_translator_top #(
  parameter int RING_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_command,
  input  logic [kst_pkg::SCAN_W-1:0]   in_scan_code,
  input  logic [kst_pkg::KEY_W-1:0]    in_table_index,
  input  logic                         in_table_shifted,
  input  logic [kst_pkg::CODE_W-1:0]   in_table_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_pop_valid,
  output logic [kst_pkg::CODE_W-1:0]   out_pop_code,
  output logic [kst_pkg::QCOUNT_W-1:0] out_queue_count,
  output logic                         out_dropped,
  output logic                         out_shift_held,
  output logic                         out_caps_held,
  output logic                         out_ctrl_held,
  output logic                         out_alt_held
);

  import kst_pkg::*;

  // key stage -> ring stage
  logic      s1_valid;
  logic      s1_ready;
  kst_beat_t s1_beat;
  mods_t     out_mods;

  // held-key map, keymap memories and the registered lookup
  kst_key_stage u_key_stage (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_scan_code     (in_scan_code),
    .in_table_index   (in_table_index),
    .in_table_shifted (in_table_shifted),
    .in_table_value   (in_table_value),
    .s1_valid         (s1_valid),
    .s1_ready         (s1_ready),
    .s1_beat          (s1_beat)
  );

  // code ring, push/pop/drop decision and the result register
  kst_ring_stage #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring_stage (
    .clk             (clk),
    .rst_n           (rst_n),
    .s1_valid        (s1_valid),
    .s1_ready        (s1_ready),
    .s1_beat         (s1_beat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pop_valid   (out_pop_valid),
    .out_pop_code    (out_pop_code),
    .out_queue_count (out_queue_count),
    .out_dropped     (out_dropped),
    .out_mods        (out_mods)
  );

  assign out_shift_held = out_mods.shift;
  assign out_caps_held  = out_mods.caps;
  assign out_ctrl_held  = out_mods.ctrl;
  assign out_alt_held   = out_mods.alt;

endmodule

// ===== verif/tb_keyboard_scancode_translator_top.sv =====
`timescale 1ns / 1ps

module tb_keyboard_scancode_translator_top;
  import kst_pkg::*;

  // Ring size used by the instance. The ring holds at most RING_SLOTS-1 codes.
  localparam int RING_SLOTS = 64;
  // The block has no meaning for command 3 and treats it as a no-op.
  localparam logic [1:0] CMD_NOP = 2'd3;
  // Number of beats in the random part.
  localparam int ITEM_TARGET = 1550;
  // Cycles in a row with no beat on either channel before the run is given up.
  localparam int STALL_LIMIT = 5000;
  // Margin waited at the end once no result is due any more.
  localparam int DRAIN_CYCLES = 8;

  // Status reported with every result beat.
  typedef struct packed {
    logic                pop_valid;
    logic [CODE_W-1:0]   pop_code;
    logic [QCOUNT_W-1:0] queue_count;
    logic                dropped;
    logic                shift;
    logic                caps;
    logic                ctrl;
    logic                alt;
  } key_status_t;

  typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIX, PH_NOISE} phase_t;

  // --------------------------------------------------------------------------
  // Scoreboard: a mirror of the held-key map, both keymaps and the code ring.
  // It also holds the statuses that are still due from the block.
  // --------------------------------------------------------------------------
  class keystroke_checker;
    bit                held [KEY_COUNT];
    logic [CODE_W-1:0] plain_map [KEY_COUNT];
    logic [CODE_W-1:0] shift_map [KEY_COUNT];
    bit                plain_set [KEY_COUNT];
    bit                shift_set [KEY_COUNT];
    logic [CODE_W-1:0] ring [RING_SLOTS];
    int unsigned       wr_ptr;
    int unsigned       rd_ptr;
    key_status_t       due_status [$];
    int                errors;

    function int unsigned ring_next(int unsigned p);
      return (p + 1 >= RING_SLOTS) ? 0 : p + 1;
    endfunction

    function int unsigned occupancy();
      return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : RING_SLOTS - rd_ptr + wr_ptr;
    endfunction

    function bit shift_down();
      return held[KEY_LSHIFT] || held[KEY_RSHIFT];
    endfunction

    // A press sets its own bit before the lookup, so a shift key reads the shifted map.
    function bit press_uses_shifted(logic [KEY_W-1:0] k);
      return shift_down() || k == KEY_LSHIFT || k == KEY_RSHIFT;
    endfunction

    function bit entry_written(logic [KEY_W-1:0] k, bit shifted);
      return shifted ? shift_set[k] : plain_set[k];
    endfunction

    function void note_beat(logic [1:0] cmd, logic [SCAN_W-1:0] scan,
                            logic [KEY_W-1:0] idx, logic tsh, logic [CODE_W-1:0] val);
      key_status_t       s;
      logic [KEY_W-1:0]  k;
      logic [CODE_W-1:0] code;
      s = '0;
      k = scan[KEY_W-1:0];
      case (cmd)
        CMD_KEY: begin
          if (scan[RELEASE_BIT]) begin
            held[k] = 1'b0;
          end else begin
            held[k] = 1'b1;
            code = shift_down() ? shift_map[k] : plain_map[k];
            if (code != '0) begin
              if (ring_next(wr_ptr) != rd_ptr) begin
                ring[wr_ptr] = code;
                wr_ptr = ring_next(wr_ptr);
              end else begin
                s.dropped = 1'b1;
              end
            end
          end
        end
        CMD_POP: begin
          if (rd_ptr != wr_ptr) begin
            s.pop_valid = 1'b1;
            s.pop_code  = ring[rd_ptr];
            rd_ptr = ring_next(rd_ptr);
          end
        end
        CMD_WRITE: begin
          if (tsh) begin
            shift_map[idx] = val;
            shift_set[idx] = 1'b1;
          end else begin
            plain_map[idx] = val;
            plain_set[idx] = 1'b1;
          end
        end
        default: ;
      endcase
      s.queue_count = QCOUNT_W'(occupancy());
      s.shift = shift_down();
      s.caps  = held[KEY_CAPS];
      s.ctrl  = held[KEY_CTRL];
      s.alt   = held[KEY_ALT];
      due_status.push_back(s);
    endfunction

    // Four-state compare, so an unknown bit from the block counts as a mismatch.
    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_beat(key_status_t got);
      key_status_t want;
      if (due_status.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing due, got %p", $time, got);
        return;
      end
      want = due_status.pop_front();
      compare_field("pop_valid", 32'(want.pop_valid), 32'(got.pop_valid));
      compare_field("pop_code", 32'(want.pop_code), 32'(got.pop_code));
      compare_field("queue_count", 32'(want.queue_count), 32'(got.queue_count));
      compare_field("dropped", 32'(want.dropped), 32'(got.dropped));
      compare_field("shift_held", 32'(want.shift), 32'(got.shift));
      compare_field("caps_held", 32'(want.caps), 32'(got.caps));
      compare_field("ctrl_held", 32'(want.ctrl), 32'(got.ctrl));
      compare_field("alt_held", 32'(want.alt), 32'(got.alt));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_command;
  logic [SCAN_W-1:0]   in_scan_code;
  logic [KEY_W-1:0]    in_table_index;
  logic                in_table_shifted;
  logic [CODE_W-1:0]   in_table_value;
  logic                out_valid;
  logic                out_ready;
  logic                out_pop_valid;
  logic [CODE_W-1:0]   out_pop_code;
  logic [QCOUNT_W-1:0] out_queue_count;
  logic                out_dropped;
  logic                out_shift_held;
  logic                out_caps_held;
  logic                out_ctrl_held;
  logic                out_alt_held;

  keyboard_scancode_translator_top #(
    .RING_DEPTH(RING_SLOTS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_scan_code     (in_scan_code),
    .in_table_index   (in_table_index),
    .in_table_shifted (in_table_shifted),
    .in_table_value   (in_table_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pop_valid    (out_pop_valid),
    .out_pop_code     (out_pop_code),
    .out_queue_count  (out_queue_count),
    .out_dropped      (out_dropped),
    .out_shift_held   (out_shift_held),
    .out_caps_held    (out_caps_held),
    .out_ctrl_held    (out_ctrl_held),
    .out_alt_held     (out_alt_held)
  );

  keystroke_checker book = new();
  int  sent_items;
  int  quiet_cycles;
  // When set, the sender puts no gaps between beats.
  bit  sender_calm;

  // 4 ns clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Result monitor and watchdog. Both sample at the rising edge. The watchdog
  // counts cycles in which neither channel moves a beat.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      book.check_beat({out_pop_valid, out_pop_code, out_queue_count, out_dropped,
                       out_shift_held, out_caps_held, out_ctrl_held, out_alt_held});
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result backpressure. Stretches of ready are broken by stalls, mostly short.
  // Some stretches are long, so the block also runs at full rate.
  // --------------------------------------------------------------------------
  initial begin
    int run;
    int stall;
    int r;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      out_ready <= 1'b1;
      repeat (run) @(negedge clk);
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 99);
        stall = (r < 70) ? $urandom_range(1, 3) :
                (r < 95) ? $urandom_range(4, 10) : $urandom_range(30, 80);
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. Every task starts and ends just after a falling edge.
  // --------------------------------------------------------------------------
  function automatic int sender_gap();
    int r;
    if (sender_calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [CODE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12)
      return '0;
    if (r < 17)
      return '1;
    return CODE_W'($urandom);
  endfunction

  // Drives one input beat and holds it until it is taken. Valid stays high
  // into the next beat unless a gap is inserted.
  task automatic drive_beat(input logic [1:0] cmd, input logic [SCAN_W-1:0] scan,
                            input logic [KEY_W-1:0] idx, input logic tsh,
                            input logic [CODE_W-1:0] val);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_scan_code     <= scan;
    in_table_index   <= idx;
    in_table_shifted <= tsh;
    in_table_value   <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_beat(cmd, scan, idx, tsh, val);
    sent_items++;
    @(negedge clk);
  endtask

  // The unused fields of each beat carry random values.
  task automatic write_beat(input bit shifted, input logic [KEY_W-1:0] k,
                            input logic [CODE_W-1:0] val);
    drive_beat(CMD_WRITE, SCAN_W'($urandom), k, shifted, val);
  endtask

  task automatic pop_beat();
    drive_beat(CMD_POP, SCAN_W'($urandom), KEY_W'($urandom), 1'($urandom), CODE_W'($urandom));
  endtask

  task automatic nop_beat();
    drive_beat(CMD_NOP, SCAN_W'($urandom), KEY_W'($urandom), 1'($urandom), CODE_W'($urandom));
  endtask

  // Before a press, fill the keymap entry it will read if that entry was never
  // written. An unwritten entry is never read.
  task automatic key_beat(input logic [SCAN_W-1:0] scan);
    logic [KEY_W-1:0] k;
    bit               sh;
    k = scan[KEY_W-1:0];
    if (!scan[RELEASE_BIT]) begin
      sh = book.press_uses_shifted(k);
      if (!book.entry_written(k, sh))
        write_beat(sh, k, pick_value());
    end
    drive_beat(CMD_KEY, scan, KEY_W'($urandom), 1'($urandom), CODE_W'($urandom));
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 3) == 0)
      return KEY_W'(KEY_LSHIFT + $urandom_range(0, 4));
    return KEY_W'($urandom_range(0, KEY_COUNT - 1));
  endfunction

  // One random beat. Its mix depends on the phase. Fill phases press often
  // enough to run the ring full, and drain phases empty it again.
  task automatic random_beat(input phase_t ph);
    int r;
    int key_pct;
    int pop_pct;
    int wr_pct;
    int rel_pct;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL:  begin key_pct = 70; pop_pct = 10; wr_pct = 12; rel_pct = 30; end
      PH_DRAIN: begin key_pct = 20; pop_pct = 65; wr_pct = 10; rel_pct = 45; end
      PH_MIX:   begin key_pct = 40; pop_pct = 30; wr_pct = 25; rel_pct = 45; end
      default:  begin key_pct = 30; pop_pct = 20; wr_pct = 20; rel_pct = 50; end
    endcase
    if (r < key_pct)
      key_beat({1'($urandom_range(0, 99) < rel_pct), pick_key()});
    else if (r < key_pct + pop_pct)
      pop_beat();
    else if (r < key_pct + pop_pct + wr_pct)
      write_beat(1'($urandom), pick_key(), pick_value());
    else
      nop_beat();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int     phase_len;
    phase_t ph;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_command       = CMD_KEY;
    in_scan_code     = '0;
    in_table_index   = '0;
    in_table_shifted = 1'b0;
    in_table_value   = '0;
    sent_items       = 0;
    quiet_cycles     = 0;
    sender_calm      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part
    pop_beat();                                   // pop with the ring empty
    drive_beat(CMD_NOP, '1, '1, 1'b1, '1);        // unused command, every field all ones
    write_beat(1'b0, 7'h00, 16'hFFFF);
    write_beat(1'b0, 7'h7F, 16'h0001);
    write_beat(1'b1, 7'h7F, 16'h8000);
    write_beat(1'b1, KEY_LSHIFT, 16'h00A5);       // left shift looks itself up shifted
    write_beat(1'b0, KEY_CAPS, 16'h0000);         // caps yields no code
    key_beat(8'h00);
    key_beat(8'h7F);
    key_beat({1'b0, KEY_CAPS});
    key_beat({1'b0, KEY_CTRL});
    key_beat({1'b0, KEY_ALT});
    key_beat({1'b0, KEY_LSHIFT});
    key_beat(8'h7F);                              // repeat press while shifted
    key_beat({1'b1, KEY_LSHIFT});
    write_beat(1'b1, KEY_RSHIFT, 16'h1234);
    key_beat({1'b0, KEY_RSHIFT});
    key_beat({1'b1, KEY_RSHIFT});
    key_beat({1'b1, KEY_CAPS});
    key_beat(8'h80);                              // release key 0
    key_beat(8'hFF);                              // release key 0x7F
    key_beat(8'hA5);                              // release of a key never pressed
    repeat (8) pop_beat();                        // drain to empty and pop at least once more

    // Random part, organized in phases
    sent_items = 0;
    while (sent_items < ITEM_TARGET) begin
      ph          = phase_t'($urandom_range(0, 3));
      sender_calm = ($urandom_range(0, 4) == 0);
      phase_len   = $urandom_range(20, 150);
      repeat (phase_len) begin
        if (sent_items < ITEM_TARGET)
          random_beat(ph);
      end
    end
    sender_calm = 1'b0;
    in_valid <= 1'b0;

    // Wait for the outstanding results. The watchdog limits this wait.
    while (book.due_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (book.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/kst_pkg.sv
hw/rtl/kst_key_stage.sv
hw/rtl/kst_ring_stage.sv
hw/rtl/keyboard_scancode_translator_top.sv
verif/tb_keyboard_scancode_translator_top.sv
